FILE: rtl/sbrtg_pkg.sv
// shared types, constants and helper functions of the sbr time grid chooser
`timescale 1ns / 1ps
package sbrtg_pkg;

    localparam int GRID_SLOTS = 16;
    localparam int SLOT_W     = 6;
    localparam int RATIO_W    = 16;
    localparam int SPF_W      = 7;
    localparam int FIXN_W     = 3;
    localparam int BORD_W     = 5;
    localparam int CNT_W      = 3;
    localparam int MASK_W     = 5;
    localparam int NUM_BORD   = 6;
    localparam int DIV_W      = SLOT_W + $clog2(GRID_SLOTS);
    localparam int DIVCNT_W   = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SPF_W;

    // q8.8 thresholds, r/256 > x  <=>  r > floor(256*x)
    localparam logic [RATIO_W-1:0] THR_LATE  = 16'd780;
    localparam logic [RATIO_W-1:0] THR_EARLY = 16'd947;
    localparam logic [RATIO_W-1:0] THR_MORE1 = 16'd1152;
    localparam logic [RATIO_W-1:0] THR_MORE2 = 16'd1920;
    localparam logic [RATIO_W-1:0] THR_FIVE  = 16'd3072;

    // largest scaled transient slot (even)
    localparam logic [BORD_W-1:0] SLOT_MAX = BORD_W'(GRID_SLOTS - 2);
    localparam logic [BORD_W-1:0] BORD_END = BORD_W'(GRID_SLOTS);
    localparam logic [BORD_W-1:0] BORD_TAIL = BORD_W'(GRID_SLOTS + 2);

    typedef logic [BORD_W-1:0] t_bord;

    typedef enum logic [1:0] {
        CLS_FIXFIX = 2'd0,
        CLS_FIXVAR = 2'd1,
        CLS_VARFIX = 2'd2,
        CLS_VARVAR = 2'd3
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIXED_COUNT = 1'b0,
        CFG_SLOTS       = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_class                       cls;
        logic [CNT_W-1:0]             count;
        logic [NUM_BORD-1:0][BORD_W-1:0] border;
        logic [MASK_W-1:0]            mask;
        logic [CNT_W-1:0]             ptr;
        t_bord                        last;
    } t_grid;

    // clamp to lo..hi, then clear bit 0
    function automatic t_bord even_clamp(input t_bord v, input t_bord lo, input t_bord hi);
        t_bord x;
        begin
            x = v;
            if (x < lo) x = lo;
            if (x > hi) x = hi;
            even_clamp = {x[BORD_W-1:1], 1'b0};
        end
    endfunction

    // evenly split fixfix borders, e*16/n
    function automatic t_bord fix_border(input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] e);
        begin
            fix_border = '0;
            case (n)
                3'd1: fix_border = (e == 3'd1) ? BORD_END : '0;
                3'd2: fix_border = BORD_W'(e) << 3;
                3'd3: begin
                    case (e)
                        3'd1:    fix_border = 5'd5;
                        3'd2:    fix_border = 5'd10;
                        3'd3:    fix_border = BORD_END;
                        default: fix_border = '0;
                    endcase
                end
                default: fix_border = BORD_W'(e) << 2;
            endcase
        end
    endfunction

endpackage

FILE: rtl/sbr_time_grid_chooser.sv
// top level of the sbr frame class and time grid chooser
`timescale 1ns / 1ps
// an item passes through the 10 divider steps in S_DIV, S_DIV then sees the divider finish,
//   and S_LOAD registers the grid decision into the output register once that is free
// a new item is taken only in S_IDLE, after the previous one has left S_LOAD
// the input side is ready again while a finished result waits in the output register
// reset (synchronous, active low): fixed count 1, 16 slots per frame,
//   trailing border 0, no result pending
module sbr_time_grid_chooser
    import sbrtg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SLOT_W-1:0]     i_peak_slot,
    input  logic [RATIO_W-1:0]    i_peak_ratio,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_frame_class,
    output logic [CNT_W-1:0]      o_envelope_count,
    output logic [BORD_W-1:0]     o_border_0,
    output logic [BORD_W-1:0]     o_border_1,
    output logic [BORD_W-1:0]     o_border_2,
    output logic [BORD_W-1:0]     o_border_3,
    output logic [BORD_W-1:0]     o_border_4,
    output logic [BORD_W-1:0]     o_border_5,
    output logic [MASK_W-1:0]     o_high_res_mask,
    output logic [CNT_W-1:0]      o_transient_pointer
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LOAD
    } t_state;

    t_state               r_state;
    logic [FIXN_W-1:0]    r_fixed_count;
    logic [SPF_W-1:0]     r_spf;
    t_bord                r_trail;
    logic [RATIO_W-1:0]   r_ratio;
    logic                 r_out_valid;
    t_grid                r_out;

    logic                 accept;
    logic                 div_done;
    t_bord                slot;
    t_grid                grid;
    logic                 out_free;

    // configuration registers; the user must write them only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_count <= FIXN_W'(1);
            r_spf         <= SPF_W'(GRID_SLOTS);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FIXED_COUNT: r_fixed_count <= i_cfg_data[FIXN_W-1:0];
                CFG_SLOTS:       r_spf         <= i_cfg_data[SPF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // scaled slot = peak_slot * 16 / slots_per_frame, clamped and made even, one quotient bit a cycle
    sbrtg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend ({i_peak_slot, {($clog2(GRID_SLOTS)){1'b0}}}),
        .i_divisor  (r_spf),
        .o_done     (div_done),
        .o_slot     (slot)
    );

    // grid decision from the held scaled slot, ratio and trailing border
    sbrtg_grid u_grid (
        .i_slot        (slot),
        .i_ratio       (r_ratio),
        .i_trail       (r_trail),
        .i_fixed_count (r_fixed_count),
        .o_grid        (grid)
    );

    // sequencer with output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_trail     <= '0;
        end else begin
            // a new result replaces the one taken in the same cycle
            if (r_state == S_LOAD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // wait until the previous result has been taken
                    if (out_free) begin
                        r_trail     <= grid.last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (accept) r_ratio <= i_peak_ratio;
        if (r_state == S_LOAD && out_free) r_out <= grid;
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_class       = r_out.cls;
    assign o_envelope_count    = r_out.count;
    assign o_border_0          = r_out.border[0];
    assign o_border_1          = r_out.border[1];
    assign o_border_2          = r_out.border[2];
    assign o_border_3          = r_out.border[3];
    assign o_border_4          = r_out.border[4];
    assign o_border_5          = r_out.border[5];
    assign o_high_res_mask     = r_out.mask;
    assign o_transient_pointer = r_out.ptr;

endmodule

FILE: rtl/sbrtg_div.sv
// iterative restoring divider that scales the peak slot onto the grid
`timescale 1ns / 1ps
module sbrtg_div
    import sbrtg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [SPF_W-1:0]  i_divisor,
    output logic              o_done,
    output t_bord             o_slot
);

    logic [DIVCNT_W-1:0] r_cnt, n_cnt;
    logic                r_done, n_done;
    logic [SPF_W:0]      r_rem, n_rem;
    logic [DIV_W-1:0]    r_num, n_num;
    logic [DIV_W-1:0]    r_quot, n_quot;
    logic [SPF_W-1:0]    r_div, n_div;
    logic [SPF_W:0]      trial;
    t_bord               clamped;

    assign trial = {r_rem[SPF_W-1:0], r_num[DIV_W-1]};

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_num  = r_num;
        n_quot = r_quot;
        n_div  = r_div;
        if (i_start) begin
            n_cnt  = DIVCNT_W'(DIV_W);
            n_rem  = '0;
            n_num  = i_dividend;
            n_quot = '0;
            n_div  = i_divisor;
        end else if (r_cnt != '0) begin
            // one quotient bit per cycle
            n_num = {r_num[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem  = trial - {1'b0, r_div};
                n_quot = {r_quot[DIV_W-2:0], 1'b1};
            end else begin
                n_rem  = trial;
                n_quot = {r_quot[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIVCNT_W'(1)) n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem  <= n_rem;
        r_num  <= n_num;
        r_quot <= n_quot;
        r_div  <= n_div;
    end

    // zero divisor saturates; otherwise clamp to the grid and make even
    always_comb begin
        if (r_div == '0 || r_quot > DIV_W'(SLOT_MAX)) clamped = SLOT_MAX;
        else clamped = {r_quot[BORD_W-1:1], 1'b0};
    end

    assign o_done = r_done;
    assign o_slot = clamped;

endmodule

FILE: rtl/sbrtg_grid.sv
// frame class, envelope borders, resolution mask and transient pointer
`timescale 1ns / 1ps
module sbrtg_grid
    import sbrtg_pkg::*;
(
    input  t_bord              i_slot,
    input  logic [RATIO_W-1:0] i_ratio,
    input  t_bord              i_trail,
    input  logic [FIXN_W-1:0]  i_fixed_count,
    output t_grid              o_grid
);

    t_bord            carry;
    t_bord            start;
    logic             tail0, trans, tail;
    logic [CNT_W-1:0] more, n, fixn, ptr;
    t_class           cls;
    t_bord            b [NUM_BORD];
    logic [MASK_W-1:0] mask;
    logic             go;

    always_comb begin
        carry = (i_trail > BORD_END) ? i_trail - BORD_END : '0;
        start = (carry != '0) ? 5'd2 : 5'd0;
        tail0 = i_slot >= 5'd4;
        trans = tail0 ? (i_ratio > THR_LATE) : (i_ratio > THR_EARLY);
        tail  = tail0 && trans;
        more  = 3'd2 + CNT_W'(i_ratio > THR_MORE1) + CNT_W'(i_ratio > THR_MORE2);
        fixn  = (i_fixed_count == '0) ? 3'd1 :
                (i_fixed_count > 3'd4) ? 3'd4 : i_fixed_count;
        for (int e = 0; e < NUM_BORD; e++) b[e] = '0;

        if (!trans) begin
            if (carry != '0) begin
                cls  = CLS_VARFIX;
                n    = 3'd2;
                b[0] = carry;
                b[1] = 5'd8;
                b[2] = BORD_END;
            end else begin
                cls = CLS_FIXFIX;
                n   = fixn;
                for (int e = 0; e < NUM_BORD; e++) begin
                    if (CNT_W'(e) <= n) b[e] = fix_border(n, CNT_W'(e));
                end
            end
        end else if (tail && carry != '0) begin
            cls  = CLS_VARVAR;
            n    = more + CNT_W'(i_ratio > THR_FIVE);
            b[0] = 5'd2;
            case (n)
                3'd2: b[1] = 5'd10;
                3'd3: begin
                    b[1] = 5'd8;
                    b[2] = 5'd14;
                end
                3'd4: begin
                    b[1] = 5'd6;
                    b[2] = 5'd10;
                    b[3] = 5'd14;
                end
                default: begin
                    b[1] = 5'd4;
                    b[2] = 5'd8;
                    b[3] = 5'd12;
                    b[4] = BORD_END;
                end
            endcase
            b[n] = BORD_TAIL;
        end else if (tail) begin
            cls = CLS_FIXVAR;
            n   = more;
            case (n)
                3'd2: b[1] = even_clamp(i_slot, 5'd10, BORD_END);
                3'd3: begin
                    b[1] = 5'd8;
                    b[2] = even_clamp(i_slot, 5'd10, BORD_END);
                end
                default: begin
                    b[1] = 5'd4;
                    b[2] = 5'd8;
                    b[3] = even_clamp(i_slot, 5'd10, BORD_END);
                end
            endcase
            b[n] = BORD_TAIL;
        end else begin
            cls  = CLS_VARFIX;
            n    = more;
            b[0] = start;
            case (n)
                3'd2: b[1] = even_clamp(i_slot, start + 5'd2, 5'd8);
                3'd3: begin
                    b[1] = even_clamp(i_slot, start + 5'd2, 5'd6);
                    b[2] = b[1] + 5'd4;
                end
                default: begin
                    b[1] = even_clamp(i_slot, start + 5'd2, 5'd6);
                    b[2] = b[1] + 5'd2;
                    b[3] = b[1] + 5'd6;
                end
            endcase
            b[n] = BORD_END;
        end

        // envelopes longer than four slots get high resolution, as does the first fixfix envelope
        mask = '0;
        for (int e = 0; e < MASK_W; e++) begin
            if (CNT_W'(e) < n && {1'b0, b[e+1]} > ({1'b0, b[e]} + 6'd4)) mask[e] = 1'b1;
        end
        if (cls == CLS_FIXFIX) mask[0] = 1'b1;

        // last envelope starting at or before the transient slot
        ptr = '0;
        go  = 1'b1;
        for (int e = 1; e < MASK_W; e++) begin
            if (go && CNT_W'(e) < n && i_slot >= b[e]) ptr = CNT_W'(e);
            else go = 1'b0;
        end

        o_grid.cls   = cls;
        o_grid.count = n;
        for (int e = 0; e < NUM_BORD; e++) o_grid.border[e] = b[e];
        o_grid.mask  = mask;
        o_grid.ptr   = ptr;
        o_grid.last  = b[n];
    end

endmodule
